>>> rtl/core/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg: shared types, codes and character classes of the line tokenizer
// Holds the lexer state record, the result word layout, the mode codes and
// the delimiter and operator tables used by the lexer and the result queue.
// ----------------------------------------------------------------------------
package clt_pkg;

	// Lexer mode codes; codes five to seven behave as between tokens.
	localparam logic [2:0] MODE_BETWEEN = 3'd0;
	localparam logic [2:0] MODE_WORD    = 3'd1;
	localparam logic [2:0] MODE_DQ      = 3'd2;
	localparam logic [2:0] MODE_SQ      = 3'd3;
	localparam logic [2:0] MODE_COMMENT = 3'd4;

	// Characters with a role of their own.
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQ     = 8'h3D;

	// At most this many result words follow from one input word.
	localparam int MAX_RESULTS = 3;

	// Result queue geometry.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic [FIFO_AW-1:0] fifo_ptr_t;
	typedef logic [FIFO_AW:0]   fifo_cnt_t;

	// One result word.
	typedef struct packed {
		logic [7:0] char_out;
		logic       token_first;
		logic       token_final;
		logic       line_done;
	} result_t;

	// Lexer state carried from one input word to the next.
	typedef struct packed {
		logic [2:0]      lex_mode;
		logic [1:0][7:0] ahead_chars;
		logic [1:0]      ahead_count;
		logic            token_open;
	} lex_state_t;

	// Result words produced by one input word.
	typedef struct packed {
		logic [1:0]          cnt;
		result_t [2:0]       res;
	} lex_out_t;

	// True for characters that end a word.
	function automatic logic is_breaker(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h3B, 8'h27, 8'h3A, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C,
			8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3C, 8'h3E, 8'h22,
			8'h20, 8'h09, 8'h23, 8'h40, 8'h21, 8'h26, 8'h7C, 8'h7E,
			8'h25, 8'h7B, 8'h7D, 8'h5E: r = 1'b1;
			default:                     r = 1'b0;
		endcase
		return r;
	endfunction

	// True for characters that open one of the two-character operators.
	function automatic logic starts_twin(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h3D, 8'h21, 8'h3C, 8'h3E, 8'h26, 8'h7C, 8'h2B, 8'h2D,
			8'h2A, 8'h2F, 8'h25, 8'h5E: r = 1'b1;
			default:                     r = 1'b0;
		endcase
		return r;
	endfunction

	// True when the pair forms one of the eighteen two-character operators.
	function automatic logic is_twin(input logic [7:0] a, input logic [7:0] b);
		logic r;
		unique case ({a, b})
			16'h3D3D, 16'h213D, 16'h3C3D, 16'h3E3D, 16'h3E3E, 16'h3C3C,
			16'h2626, 16'h7C7C, 16'h2B2B, 16'h2D2D, 16'h2B3D, 16'h2D3D,
			16'h2A3D, 16'h2F3D, 16'h253D, 16'h263D, 16'h7C3D,
			16'h5E3D: r = 1'b1;
			default:   r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/clt_in_if.sv
// ----------------------------------------------------------------------------
// clt_in_if: character channel of the line tokenizer
// Carries one source character and its line end flag per word.
// ----------------------------------------------------------------------------
interface clt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       line_last;

	modport source(output valid, output char_in, output line_last, input ready);
	modport sink(input valid, input char_in, input line_last, output ready);
endinterface

>>> rtl/core/clt_out_if.sv
// ----------------------------------------------------------------------------
// clt_out_if: token channel of the line tokenizer
// Carries one kept character with its token and line marks per word.
// ----------------------------------------------------------------------------
interface clt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       token_first;
	logic       token_final;
	logic       line_done;

	modport source(output valid, output char_out, output token_first,
		output token_final, output line_done, input ready);
	modport sink(input valid, input char_out, input token_first,
		input token_final, input line_done, output ready);
endinterface

>>> rtl/core/clt_lexer.sv
// ----------------------------------------------------------------------------
// clt_lexer: one lexing pass over the held characters and the new one
// Combines up to two held characters with the incoming one, walks them in at
// most three short steps and yields up to three result words and the state.
// ----------------------------------------------------------------------------
module clt_lexer (
	input  clt_pkg::lex_state_t state,
	input  logic [7:0]          char_in,
	input  logic                line_last,
	output clt_pkg::lex_state_t state_next,
	output clt_pkg::lex_out_t   result
);

	logic [3:0][7:0] buf4;
	logic [1:0]      nh;
	logic [1:0]      n;
	logic [1:0]      pos;
	logic [1:0]      k;
	logic [1:0]      avail;
	logic [1:0]      step;
	logic [1:0]      rem;
	logic [1:0]      len;
	logic [1:0]      em_n;
	logic [2:0][7:0] em_ch;
	logic [2:0]      em_first;
	logic [2:0]      em_fin;
	logic            stop;
	logic            hn;
	logic            fin;
	logic [7:0]      c;
	logic [7:0]      nxt;
	logic [7:0]      nxt2;
	logic [7:0]      q;
	logic [2:0]      mode;
	logic            topen;
	clt_pkg::result_t [2:0] res;

	// Walk the buffered characters; every step consumes at least one or stops.
	always_comb begin
		mode  = state.lex_mode;
		topen = state.token_open;
		pos   = 2'd0;
		k     = 2'd0;
		stop  = 1'b0;
		res   = '0;
		avail = 2'd0;
		step  = 2'd0;
		len   = 2'd0;
		hn    = 1'b0;
		fin   = 1'b0;
		c     = 8'h00;
		nxt   = 8'h00;
		nxt2  = 8'h00;
		q     = 8'h00;
		em_n  = 2'd0;
		em_ch = '0;
		em_first = '0;
		em_fin   = '0;

		nh = (state.ahead_count > 2'd2) ? 2'd2 : state.ahead_count;
		n  = nh + 2'd1;
		buf4[0] = (nh != 2'd0) ? state.ahead_chars[0] : char_in;
		buf4[1] = (nh == 2'd2) ? state.ahead_chars[1] :
			((nh == 2'd1) ? char_in : 8'h00);
		buf4[2] = (nh == 2'd2) ? char_in : 8'h00;
		buf4[3] = 8'h00;

		for (int it = 0; it < clt_pkg::MAX_RESULTS; it++) begin
			em_n     = 2'd0;
			em_ch    = '0;
			em_first = '0;
			em_fin   = '0;
			step     = 2'd0;
			if (!stop && pos < n) begin
				c     = buf4[pos];
				avail = n - pos;
				hn    = avail >= 2'd2;
				nxt   = hn ? buf4[pos + 2'd1] : 8'h00;
				nxt2  = buf4[pos + 2'd2];
				if (mode == clt_pkg::MODE_COMMENT) begin
					step = 2'd1;
				end else if (mode == clt_pkg::MODE_WORD) begin
					if (!hn && !line_last) begin
						stop = 1'b1;
					end else begin
						fin = hn ? clt_pkg::is_breaker(nxt) : 1'b1;
						em_n = 2'd1; em_ch[0] = c; em_first[0] = 1'b0; em_fin[0] = fin;
						if (fin) begin
							mode  = clt_pkg::MODE_BETWEEN;
							topen = 1'b0;
						end
						step = 2'd1;
					end
				end else if (mode == clt_pkg::MODE_DQ || mode == clt_pkg::MODE_SQ) begin
					q = (mode == clt_pkg::MODE_DQ) ? clt_pkg::CH_DQUOTE : clt_pkg::CH_SQUOTE;
					if (c == q) begin
						em_n = 2'd1; em_ch[0] = c; em_first[0] = 1'b0; em_fin[0] = 1'b1;
						mode  = clt_pkg::MODE_BETWEEN;
						topen = 1'b0;
						step  = 2'd1;
					end else if (!hn && !line_last) begin
						stop = 1'b1;
					end else begin
						em_n = 2'd1; em_ch[0] = c; em_first[0] = 1'b0; em_fin[0] = !hn;
						if (!hn) begin
							mode  = clt_pkg::MODE_BETWEEN;
							topen = 1'b0;
						end
						step = 2'd1;
					end
				end else if (c == clt_pkg::CH_SPACE) begin
					step = 2'd1;
				end else if (c == clt_pkg::CH_DQUOTE || c == clt_pkg::CH_SQUOTE) begin
					if (!hn && !line_last) begin
						stop = 1'b1;
					end else begin
						em_n = 2'd1; em_ch[0] = c; em_first[0] = 1'b1; em_fin[0] = !hn;
						if (hn) begin
							mode  = (c == clt_pkg::CH_DQUOTE) ? clt_pkg::MODE_DQ :
								clt_pkg::MODE_SQ;
							topen = 1'b1;
						end else begin
							mode = clt_pkg::MODE_BETWEEN;
						end
						step = 2'd1;
					end
				end else if (clt_pkg::is_breaker(c)) begin
					// A slash waits for its follower; a double slash opens a comment.
					if (c == clt_pkg::CH_SLASH && !hn && !line_last) begin
						stop = 1'b1;
					end else if (c == clt_pkg::CH_SLASH && hn && nxt == clt_pkg::CH_SLASH) begin
						mode  = clt_pkg::MODE_COMMENT;
						topen = 1'b0;
						step  = 2'd2;
					end else begin
						// Longest operator match, holding back when it is not yet decided.
						if (avail == 2'd3 || line_last) begin
							if (avail == 2'd3 && (c == clt_pkg::CH_LT || c == clt_pkg::CH_GT) &&
								nxt == c && nxt2 == clt_pkg::CH_EQ) begin
								len = 2'd3;
							end else if (hn && clt_pkg::is_twin(c, nxt)) begin
								len = 2'd2;
							end else begin
								len = 2'd1;
							end
						end else if (avail == 2'd2) begin
							if ((c == clt_pkg::CH_LT || c == clt_pkg::CH_GT) && nxt == c) begin
								stop = 1'b1;
							end
							len = clt_pkg::is_twin(c, nxt) ? 2'd2 : 2'd1;
						end else begin
							if (clt_pkg::starts_twin(c)) begin
								stop = 1'b1;
							end
							len = 2'd1;
						end
						if (!stop) begin
							em_n = len;
							for (int j = 0; j < clt_pkg::MAX_RESULTS; j++) begin
								em_ch[j]    = buf4[pos + 2'(j)];
								em_first[j] = (j == 0);
								em_fin[j]   = (2'(j + 1) == len);
							end
							mode  = clt_pkg::MODE_BETWEEN;
							topen = 1'b0;
							step  = len;
						end
					end
				end else begin
					if (!hn && !line_last) begin
						stop = 1'b1;
					end else begin
						fin = hn ? clt_pkg::is_breaker(nxt) : 1'b1;
						em_n = 2'd1; em_ch[0] = c; em_first[0] = 1'b1; em_fin[0] = fin;
						if (!fin) begin
							mode  = clt_pkg::MODE_WORD;
							topen = 1'b1;
						end else begin
							mode = clt_pkg::MODE_BETWEEN;
						end
						step = 2'd1;
					end
				end
				pos = pos + step;
				// Append the characters of this step to the result words.
				for (int j = 0; j < clt_pkg::MAX_RESULTS; j++) begin
					if (2'(j) < em_n && k < 2'd3) begin
						res[k].char_out    = em_ch[j];
						res[k].token_first = em_first[j];
						res[k].token_final = em_fin[j];
						res[k].line_done   = 1'b0;
						k = k + 2'd1;
					end
				end
			end
		end

		// Line end flushes everything; otherwise the unresolved tail is held.
		state_next.token_open = topen;
		state_next.lex_mode   = mode;
		rem = 2'd0;
		if (line_last) begin
			state_next.lex_mode    = clt_pkg::MODE_BETWEEN;
			state_next.token_open  = 1'b0;
			state_next.ahead_count = 2'd0;
			state_next.ahead_chars = '0;
			if (k == 2'd0) begin
				res[0] = '0;
				k = 2'd1;
			end
			res[k - 2'd1].line_done = 1'b1;
		end else begin
			rem = n - pos;
			if (rem > 2'd2) begin
				pos = n - 2'd2;
				rem = 2'd2;
			end
			state_next.ahead_chars[0] = (rem >= 2'd1) ? buf4[pos] : 8'h00;
			state_next.ahead_chars[1] = (rem >= 2'd2) ? buf4[pos + 2'd1] : 8'h00;
			state_next.ahead_count    = rem;
		end
		result.cnt = k;
		result.res = res;
	end

endmodule

>>> rtl/core/clt_fifo.sv
// ----------------------------------------------------------------------------
// clt_fifo: result queue of the line tokenizer
// Takes up to three result words in a cycle and hands out one word a cycle
// while the token channel is ready; reports room while three more words fit.
// ----------------------------------------------------------------------------
module clt_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            push_n,
	input  clt_pkg::result_t [2:0] push_data,
	output logic                  room,
	clt_out_if.source             tok
);

	clt_pkg::result_t   mem_q [clt_pkg::FIFO_DEPTH];
	clt_pkg::fifo_ptr_t head_q;
	clt_pkg::fifo_ptr_t tail_q;
	clt_pkg::fifo_cnt_t count_q;
	logic               pop;

	assign pop  = tok.valid && tok.ready;
	assign room = count_q <= clt_pkg::fifo_cnt_t'(clt_pkg::FIFO_DEPTH - clt_pkg::MAX_RESULTS);

	// Head word drives the channel.
	assign tok.valid       = count_q != '0;
	assign tok.char_out    = mem_q[head_q].char_out;
	assign tok.token_first = mem_q[head_q].token_first;
	assign tok.token_final = mem_q[head_q].token_final;
	assign tok.line_done   = mem_q[head_q].line_done;

	// Storage is written at consecutive places from the tail.
	always_ff @(posedge clk) begin
		for (int j = 0; j < clt_pkg::MAX_RESULTS; j++) begin
			if (2'(j) < push_n) begin
				mem_q[tail_q + clt_pkg::fifo_ptr_t'(j)] <= push_data[j];
			end
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + clt_pkg::fifo_ptr_t'(push_n);
			head_q  <= head_q + clt_pkg::fifo_ptr_t'(pop);
			count_q <= count_q + clt_pkg::fifo_cnt_t'(push_n) - clt_pkg::fifo_cnt_t'(pop);
		end
	end

	// The queue never overfills.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= clt_pkg::fifo_cnt_t'(clt_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	// Words are only written while the queue had room for a full burst.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room)
		else $error("result words written without room");

	// A word on offer stays, with its character unchanged, until it is taken.
	a_offer_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && !tok.ready |=> tok.valid && $stable(tok.char_out))
		else $error("offered result word changed before it was taken");

endmodule

>>> rtl/core/c_line_tokenizer_top.sv
// ----------------------------------------------------------------------------
// c_line_tokenizer_top: C-style line tokenizer
// Accepts one character word a cycle, lexes it in a single registered pass
// and queues the resulting token character words for the output channel.
// ----------------------------------------------------------------------------
// Path: a result word passes the input register, then the queue, before it is
// offered on the token channel; the input register holds its character while
// the queue has no room for a full burst.
// Throughput: one character word per cycle while results drain at one word
// per cycle; the eight-word result queue sets how long a burst of three
// results per character can be absorbed before input is held off.
// Reset: arst_n clears the lexer state, the input stage and the queue at once.
module c_line_tokenizer_top (
	input  logic      clk,
	input  logic      arst_n,
	clt_in_if.sink    chr,
	clt_out_if.source tok
);

	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                last_s1;
	logic                fire_s1;
	logic                room;
	logic [1:0]          push_n;
	clt_pkg::lex_state_t state_q;
	clt_pkg::lex_state_t state_next;
	clt_pkg::lex_out_t   lex_res;

	// The input stage empties into the queue whenever a full burst fits.
	assign fire_s1   = valid_s1 && room;
	assign chr.ready = !valid_s1 || room;
	assign push_n    = fire_s1 ? lex_res.cnt : 2'd0;

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chr.valid && chr.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (chr.valid && chr.ready) begin
			char_s1 <= chr.char_in;
			last_s1 <= chr.line_last;
		end
	end

	// Lexer state advances once per processed character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.lex_mode    <= clt_pkg::MODE_BETWEEN;
			state_q.ahead_chars <= '0;
			state_q.ahead_count <= 2'd0;
			state_q.token_open  <= 1'b0;
		end else if (fire_s1) begin
			state_q <= state_next;
		end
	end

	clt_lexer u_lexer (
		.state      (state_q),
		.char_in    (char_s1),
		.line_last  (last_s1),
		.state_next (state_next),
		.result     (lex_res)
	);

	clt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_data (lex_res.res),
		.room      (room),
		.tok       (tok)
	);

	// A line end always yields at least one result word.
	a_eol_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_s1 |-> push_n != 2'd0)
		else $error("line end produced no result word");

	// After a line end nothing is held and the lexer is between tokens.
	a_eol_flush: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_s1 |=> state_q.lex_mode == clt_pkg::MODE_BETWEEN &&
		state_q.ahead_count == 2'd0)
		else $error("line end left held characters");

	// No more than two characters are ever held back.
	a_ahead_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.ahead_count != 2'd3)
		else $error("held character count out of range");

endmodule
